@@ design/lprt_pkg.sv @@
// Types, codes and helpers shared by the IPv4 route table core.
// No dependencies; imported by lprt_cell, lprt_pick_tree and the top level.
`timescale 1ns / 1ps

package lprt_pkg;

    localparam int ADDR_W   = 32;
    localparam int PLEN_W   = 6;
    localparam int METRIC_W = 16;
    localparam int IFACE_W  = 4;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int MAX_PLEN = 32;
    localparam int S_DATA_W = 96;   // 90 payload bits padded to bytes
    localparam int M_DATA_W = 56;   // 55 payload bits padded to bytes

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_HOST_BITS = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   dest;
        logic [PLEN_W-1:0]   plen;
        logic [ADDR_W-1:0]   gateway;
        logic [METRIC_W-1:0] metric;
        logic [IFACE_W-1:0]  iface;
    } entry_t;

    typedef struct packed {
        func_t             op;
        entry_t            ent;
        logic [ADDR_W-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic insert;    // sorted insert, cells at or after the slot shift right
        logic replace;   // overwrite the last cell (default route)
        logic remove;    // cells at or after the match shift left
    } cell_ctl_t;

    typedef struct packed {
        logic                hit;
        logic [ADDR_W-1:0]   gateway;
        logic [IFACE_W-1:0]  iface;
        logic [METRIC_W-1:0] metric;
    } pick_t;

    // plen is already saturated to 32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        if (plen == '0) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (PLEN_W'(MAX_PLEN) - plen);
        end
        return m;
    endfunction

    // a sorts strictly before b: longer prefix, then lower dest, then lower metric
    function automatic logic sorts_before(input entry_t a, input entry_t b);
        logic r;
        if (a.plen != b.plen) begin
            r = (a.plen > b.plen);
        end else if (a.dest != b.dest) begin
            r = (a.dest < b.dest);
        end else begin
            r = (a.metric < b.metric);
        end
        return r;
    endfunction

endpackage

@@ design/ipv4_longest_prefix_route_table_core.sv @@
// IPv4 route table, sorted chain of cells with longest-prefix lookup.
// For add, the result is loaded into the output register after the execute state; delete
// and lookup first wait for the registered priority tree over the cells. s_tready returns
// in the same cycle that the result is loaded, so a new item is taken only after the last
// item's result, and later while a held result blocks the output register.
// aresetn (sync, low) empties the table and clears control; cell contents are kept.
`timescale 1ns / 1ps

module ipv4_longest_prefix_route_table_core import lprt_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int NUM_IFACES  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // dest_addr[31:0], prefix_len[37:32], next_hop[69:38], route_metric[85:70],
    // out_iface[89:86], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[1:0], hit[2], hit_gateway[34:3], hit_iface[38:35], hit_metric[54:39],
    // zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int LEAF_N   = 1 << $clog2(TABLE_DEPTH);
    localparam int TREE_LAT = $clog2(TABLE_DEPTH) + 1;
    localparam int WAIT_W   = $clog2(TREE_LAT + 1);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                hasdef_reg, hasdef_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    status_t             status_reg, status_next;
    pick_t               res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    cell_ctl_t           ctl;

    entry_t              ent [TABLE_DEPTH];
    logic                sb  [TABLE_DEPTH];
    pick_t               leaf [LEAF_N];
    pick_t               root;

    logic [PLEN_W-1:0]   in_plen;
    logic [IFACE_W-1:0]  in_iface;

    // input beat decode with prefix saturation and interface clamp
    always_comb begin
        in_plen  = (s_tdata[37:32] > PLEN_W'(MAX_PLEN)) ? PLEN_W'(MAX_PLEN) : s_tdata[37:32];
        in_iface = (9'(s_tdata[89:86]) >= 9'(NUM_IFACES)) ? IFACE_W'(NUM_IFACES - 1)
                                                          : s_tdata[89:86];
    end

    // ---- cell chain ----
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            entry_t left_ent;
            logic   left_sb;
            entry_t right_ent;

            if (gi == 0) begin : g_first
                assign left_ent = cmd_reg.ent;
                assign left_sb  = 1'b0;
            end else begin : g_mid
                assign left_ent = ent[gi-1];
                assign left_sb  = sb[gi-1];
            end

            if (gi == TABLE_DEPTH - 1) begin : g_last
                assign right_ent = ent[gi];
            end else begin : g_inner
                assign right_ent = ent[gi+1];
            end

            lprt_cell #(
                .CELL_IDX (gi),
                .CNT_W    (CNT_W)
            ) u_cell (
                .aclk      (aclk),
                .cmd       (cmd_reg),
                .ctl       (ctl),
                .count     (count_reg),
                .left_ent  (left_ent),
                .left_sb   (left_sb),
                .right_ent (right_ent),
                .ent       (ent[gi]),
                .sb        (sb[gi]),
                .leaf      (leaf[gi])
            );
        end

        for (gi = TABLE_DEPTH; gi < LEAF_N; gi++) begin : g_pad
            assign leaf[gi] = '0;
        end
    endgenerate

    lprt_pick_tree #(
        .N (TABLE_DEPTH)
    ) u_tree (
        .aclk (aclk),
        .leaf (leaf),
        .root (root)
    );

    // ---- control ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            hasdef_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            hasdef_reg   <= hasdef_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        wait_reg    <= wait_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        hasdef_next   = hasdef_reg;
        wait_next     = wait_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ctl           = '0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next.op          = func_t'(s_tuser);
                    cmd_next.ent.dest    = s_tdata[31:0];
                    cmd_next.ent.plen    = in_plen;
                    cmd_next.ent.gateway = s_tdata[69:38];
                    cmd_next.ent.metric  = s_tdata[85:70];
                    cmd_next.ent.iface   = in_iface;
                    cmd_next.mask        = prefix_mask(in_plen);
                    wait_next            = '0;
                    state_next           = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_next = '0;
                if (wait_reg != WAIT_W'(TREE_LAT)) begin
                    wait_next = wait_reg + 1'b1;
                end
                case (cmd_reg.op)
                    FUNC_ADD: begin
                        state_next = ST_RESP;
                        if ((cmd_reg.ent.dest & ~cmd_reg.mask) != '0) begin
                            status_next = STATUS_HOST_BITS;
                        end else if (cmd_reg.ent.plen == '0 && hasdef_reg) begin
                            // the default route is always the last entry
                            ctl.replace = 1'b1;
                            status_next = STATUS_OK;
                        end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            status_next = STATUS_FULL;
                        end else begin
                            ctl.insert  = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = STATUS_OK;
                            if (cmd_reg.ent.plen == '0) begin
                                hasdef_next = 1'b1;
                            end
                        end
                    end
                    FUNC_DELETE: begin
                        if (wait_reg == WAIT_W'(TREE_LAT)) begin
                            state_next = ST_RESP;
                            if (root.hit) begin
                                ctl.remove  = 1'b1;
                                count_next  = count_reg - 1'b1;
                                status_next = STATUS_OK;
                                if (cmd_reg.ent.plen == '0) begin
                                    hasdef_next = 1'b0;
                                end
                            end else begin
                                status_next = STATUS_NOT_FOUND;
                            end
                        end
                    end
                    FUNC_LOOKUP: begin
                        if (wait_reg == WAIT_W'(TREE_LAT)) begin
                            state_next = ST_RESP;
                            if (root.hit) begin
                                res_next    = root;
                                status_next = STATUS_OK;
                            end else begin
                                status_next = STATUS_NOT_FOUND;
                            end
                        end
                    end
                    default: begin
                        state_next  = ST_RESP;
                        status_next = STATUS_OK;
                    end
                endcase
            end

            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_reg.metric, res_reg.iface, res_reg.gateway,
                                     res_reg.hit, status_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ design/lprt_cell.sv @@
// One slot of the sorted route chain: holds an entry, compares it against
// the current command and shifts toward either neighbor. Uses lprt_pkg.
`timescale 1ns / 1ps

module lprt_cell import lprt_pkg::*; #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
) (
    input  logic             aclk,
    input  cmd_t             cmd,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] count,
    input  entry_t           left_ent,
    input  logic             left_sb,
    input  entry_t           right_ent,
    output entry_t           ent,
    output logic             sb,
    output pick_t            leaf
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   occupied;
    logic   is_last;
    logic   ge;
    logic   eq;
    logic   match;

    assign occupied = (CNT_W'(CELL_IDX) < count);
    assign is_last  = (CNT_W'(CELL_IDX + 1) == count);

    // empty slots sort after everything, so the insert slot is the first sb cell
    assign sb = !occupied || sorts_before(cmd.ent, ent_reg);
    // first cell whose key is not below the request; equal keys sit together
    assign ge = !occupied || !sorts_before(ent_reg, cmd.ent);
    assign eq = occupied && (ent_reg.dest == cmd.ent.dest) &&
                (ent_reg.plen == cmd.ent.plen) && (ent_reg.metric == cmd.ent.metric);
    assign match = occupied &&
                   (((cmd.ent.dest ^ ent_reg.dest) & prefix_mask(ent_reg.plen)) == '0);

    always_comb begin
        leaf.hit     = (cmd.op == FUNC_LOOKUP) ? match : eq;
        leaf.gateway = ent_reg.gateway;
        leaf.iface   = ent_reg.iface;
        leaf.metric  = ent_reg.metric;
    end

    always_comb begin
        ent_next = ent_reg;
        if (ctl.insert && sb) begin
            ent_next = left_sb ? left_ent : cmd.ent;
        end
        if (ctl.replace && is_last) begin
            ent_next = cmd.ent;
        end
        if (ctl.remove && ge) begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

@@ design/lprt_pick_tree.sv @@
// Registered priority tree: returns the lowest-indexed flagged leaf.
// One register level per tree level plus one on the leaves. Uses lprt_pkg.
`timescale 1ns / 1ps

module lprt_pick_tree import lprt_pkg::*; #(
    parameter int N = 64
) (
    input  logic  aclk,
    input  pick_t leaf [1 << $clog2(N)],
    output pick_t root
);

    localparam int LEVELS = $clog2(N);
    localparam int PAD    = 1 << LEVELS;

    pick_t node [LEVELS+1][PAD];

    always_ff @(posedge aclk) begin
        for (int k = 0; k < PAD; k++) begin
            node[0][k] <= leaf[k];
        end
        for (int l = 1; l <= LEVELS; l++) begin
            for (int k = 0; k < PAD; k++) begin
                if (k < (PAD >> l)) begin
                    node[l][k] <= node[l-1][2*k].hit ? node[l-1][2*k] : node[l-1][2*k+1];
                end else begin
                    node[l][k] <= '0;
                end
            end
        end
    end

    assign root = node[LEVELS][0];

endmodule
